// File: rtl/pcse_pkg.sv
// types, codes and helpers shared by the pulse channel files
package pcse_pkg;

   // event codes carried in req_type
   localparam logic [3:0] EV_TICK       = 4'd0;
   localparam logic [3:0] EV_LEN_CLK    = 4'd1;
   localparam logic [3:0] EV_ENV_CLK    = 4'd2;
   localparam logic [3:0] EV_SWEEP_CLK  = 4'd3;
   localparam logic [3:0] EV_TRIGGER    = 4'd4;
   localparam logic [3:0] EV_FREQ_LO    = 4'd5;
   localparam logic [3:0] EV_FREQ_HI    = 4'd6;
   localparam logic [3:0] EV_LEN_LOAD   = 4'd7;
   localparam logic [3:0] EV_LEN_ENABLE = 4'd8;

   // configuration register indexes
   localparam logic [2:0] CSR_SWEEP_PERIOD   = 3'd0;
   localparam logic [2:0] CSR_SWEEP_SUBTRACT = 3'd1;
   localparam logic [2:0] CSR_SWEEP_SHIFT    = 3'd2;
   localparam logic [2:0] CSR_DUTY_SELECT    = 3'd3;
   localparam logic [2:0] CSR_ENV_START_VOL  = 3'd4;
   localparam logic [2:0] CSR_ENV_INCREASE   = 3'd5;
   localparam logic [2:0] CSR_ENV_PERIOD     = 3'd6;

   localparam logic [3:0]  SWEEP_IDLE_RELOAD = 4'd8;
   localparam logic [11:0] TIMER_BASE        = 12'd2048;
   localparam logic [6:0]  LENGTH_FULL       = 7'd64;
   localparam logic [3:0]  VOLUME_MAX        = 4'd15;

   typedef struct packed {
      logic [3:0] req_type;
      logic [7:0] data_byte;
      logic       length_on;
      logic       extra_clock_cond;
   } req_beat_type;

   typedef struct packed {
      logic [3:0]  amplitude;
      logic        channel_on;
      logic [10:0] frequency;
   } rsp_beat_type;

   typedef struct packed {
      logic [2:0] sweep_period;
      logic       sweep_subtract;
      logic [2:0] sweep_shift;
      logic [1:0] duty_select;
      logic [3:0] env_start_volume;
      logic       env_increase;
      logic [2:0] env_period;
   } cfg_type;

   // duty waveforms, msb first
   function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] pos);
      logic [7:0] pattern;
      case (sel)
         2'd0:    pattern = 8'b0000_0001;
         2'd1:    pattern = 8'b0000_0011;
         2'd2:    pattern = 8'b0000_1111;
         default: pattern = 8'b1111_1100;
      endcase
      return pattern[3'd7 - pos];
   endfunction

   // sweep target, bit 11 set means overflow past the 11-bit range
   function automatic logic [11:0] sweep_target(input logic [10:0] shadow,
                                                input logic [2:0]  shift,
                                                input logic        subtract);
      logic [10:0] delta;
      delta = shadow >> shift;
      if (subtract) return {1'b0, shadow} - {1'b0, delta};
      else          return {1'b0, shadow} + {1'b0, delta};
   endfunction

endpackage

// File: rtl/pulse_channel_sweep_envelope_top.sv
// top level of the pulse channel with sweep, envelope and length counter
// a beat waits in the input register, and its result is registered in the result register on rsp
// throughput: one beat per cycle while not stalled, set by the single-pass state update in pcse_core
// req_stall rises only while both the input register and the result register are full
// and the result is held off by rsp_stall
// reset (synchronous, active high) empties both registers and clears all channel state
module pulse_channel_sweep_envelope_top
   import pcse_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // event channel
   input  logic         req_valid,
   output logic         req_stall,
   input  req_beat_type req_data,
   // result channel
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_beat_type rsp_data,
   // configuration writes
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [7:0]   csr_wdata
);

   cfg_type      cfg;
   rsp_beat_type next_result;

   // input register holds the accepted beat until the core has consumed it
   logic         in_valid_ff, in_valid_in;
   req_beat_type in_beat_ff;
   // result register, parts the result side from the event side
   logic         out_valid_ff, out_valid_in;
   rsp_beat_type out_beat_ff;

   logic req_take;
   logic advance;

   // the core steps whenever a beat is held and the result register is free or being emptied
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_beat_ff;

   pcse_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // all state changes land at the edge where the beat moves on
   pcse_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .step   (advance),
      .item   (in_beat_ff),
      .result (next_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_beat_ff <= req_data;
      end
      if (advance) begin
         out_beat_ff <= next_result;
      end
   end

endmodule

// File: rtl/pcse_csr.sv
// configuration register bank of the pulse channel
module pcse_csr
   import pcse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata,
   output cfg_type    cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SWEEP_PERIOD:   cfg_in.sweep_period     = csr_wdata[2:0];
            CSR_SWEEP_SUBTRACT: cfg_in.sweep_subtract   = csr_wdata[0];
            CSR_SWEEP_SHIFT:    cfg_in.sweep_shift      = csr_wdata[2:0];
            CSR_DUTY_SELECT:    cfg_in.duty_select      = csr_wdata[1:0];
            CSR_ENV_START_VOL:  cfg_in.env_start_volume = csr_wdata[3:0];
            CSR_ENV_INCREASE:   cfg_in.env_increase     = csr_wdata[0];
            CSR_ENV_PERIOD:     cfg_in.env_period       = csr_wdata[2:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/pcse_core.sv
// channel state and its per-event update
module pcse_core
   import pcse_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         step,
   input  req_beat_type item,
   output rsp_beat_type result
);

   logic [13:0] period_count_ff, period_count_in;
   logic [2:0]  duty_position_ff, duty_position_in;
   logic [10:0] freq_value_ff, freq_value_in;
   logic [10:0] shadow_value_ff, shadow_value_in;
   logic [3:0]  sweep_count_ff, sweep_count_in;
   logic        sweep_active_ff, sweep_active_in;
   logic [2:0]  env_count_ff, env_count_in;
   logic [3:0]  volume_now_ff, volume_now_in;
   logic [6:0]  length_count_ff, length_count_in;
   logic        length_active_ff, length_active_in;
   logic        enabled_flag_ff, enabled_flag_in;

   logic [11:0] sweep_first, sweep_second, trig_check;
   logic [3:0]  sweep_dec, sweep_reload;
   logic [2:0]  env_dec;
   logic [6:0]  length_dec;
   logic [11:0] timer_span;

   // sweep: first calc on shadow, second on the freshly stored value
   assign sweep_first  = sweep_target(shadow_value_ff, cfg.sweep_shift, cfg.sweep_subtract);
   assign sweep_second = sweep_target(sweep_first[10:0], cfg.sweep_shift, cfg.sweep_subtract);
   assign trig_check   = sweep_target(freq_value_ff, cfg.sweep_shift, cfg.sweep_subtract);

   assign sweep_dec    = (sweep_count_ff != 4'd0) ? sweep_count_ff - 4'd1 : 4'd0;
   assign sweep_reload = (cfg.sweep_period != 3'd0) ? {1'b0, cfg.sweep_period}
                                                     : SWEEP_IDLE_RELOAD;
   assign env_dec      = (env_count_ff != 3'd0) ? env_count_ff - 3'd1 : 3'd0;
   assign length_dec   = (length_count_ff != 7'd0) ? length_count_ff - 7'd1 : 7'd0;
   assign timer_span   = TIMER_BASE - {1'b0, freq_value_ff};

   always_comb begin
      period_count_in  = period_count_ff;
      duty_position_in = duty_position_ff;
      freq_value_in    = freq_value_ff;
      shadow_value_in  = shadow_value_ff;
      sweep_count_in   = sweep_count_ff;
      sweep_active_in  = sweep_active_ff;
      env_count_in     = env_count_ff;
      volume_now_in    = volume_now_ff;
      length_count_in  = length_count_ff;
      length_active_in = length_active_ff;
      enabled_flag_in  = enabled_flag_ff;

      unique case (item.req_type)
         EV_TICK: begin
            if (period_count_ff <= 14'd1) begin
               period_count_in  = {timer_span, 2'b00};
               duty_position_in = duty_position_ff + 3'd1;
            end else begin
               period_count_in = period_count_ff - 14'd1;
            end
         end
         EV_LEN_CLK: begin
            if (length_active_ff) begin
               length_count_in = length_dec;
               if (length_dec == 7'd0) enabled_flag_in = 1'b0;
            end
         end
         EV_ENV_CLK: begin
            if (cfg.env_period != 3'd0) begin
               if (env_dec == 3'd0) begin
                  env_count_in = cfg.env_period;
                  if (cfg.env_increase && volume_now_ff < VOLUME_MAX)
                     volume_now_in = volume_now_ff + 4'd1;
                  else if (!cfg.env_increase && volume_now_ff != 4'd0)
                     volume_now_in = volume_now_ff - 4'd1;
               end else begin
                  env_count_in = env_dec;
               end
            end
         end
         EV_SWEEP_CLK: begin
            if (sweep_dec == 4'd0) begin
               sweep_count_in = sweep_reload;
               if (sweep_active_ff && cfg.sweep_period != 3'd0) begin
                  if (sweep_first[11]) begin
                     enabled_flag_in = 1'b0;
                  end else if (cfg.sweep_shift != 3'd0) begin
                     freq_value_in   = sweep_first[10:0];
                     shadow_value_in = sweep_first[10:0];
                     if (sweep_second[11]) enabled_flag_in = 1'b0;
                  end
               end
            end else begin
               sweep_count_in = sweep_dec;
            end
         end
         EV_TRIGGER: begin
            enabled_flag_in = !(cfg.sweep_shift != 3'd0 && trig_check[11]);
            shadow_value_in = freq_value_ff;
            sweep_count_in  = sweep_reload;
            sweep_active_in = (cfg.sweep_period != 3'd0) || (cfg.sweep_shift != 3'd0);
            volume_now_in   = cfg.env_start_volume;
            env_count_in    = cfg.env_period;
            if (length_count_ff == 7'd0) length_count_in = LENGTH_FULL;
         end
         EV_FREQ_LO: freq_value_in = {freq_value_ff[10:8], item.data_byte};
         EV_FREQ_HI: freq_value_in = {item.data_byte[2:0], freq_value_ff[7:0]};
         EV_LEN_LOAD: length_count_in = LENGTH_FULL - {1'b0, item.data_byte[5:0]};
         EV_LEN_ENABLE: begin
            if (!length_active_ff && item.length_on && item.extra_clock_cond) begin
               length_active_in = 1'b1;
               length_count_in  = length_dec;
               if (length_dec == 7'd0) enabled_flag_in = 1'b0;
            end else begin
               length_active_in = item.length_on;
            end
         end
         default: ;
      endcase
   end

   assign result.amplitude  = duty_bit(cfg.duty_select, duty_position_in) ? volume_now_in
                                                                          : 4'd0;
   assign result.channel_on = enabled_flag_in;
   assign result.frequency  = freq_value_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_count_ff  <= '0;
         duty_position_ff <= '0;
         freq_value_ff    <= '0;
         shadow_value_ff  <= '0;
         sweep_count_ff   <= '0;
         sweep_active_ff  <= 1'b0;
         env_count_ff     <= '0;
         volume_now_ff    <= '0;
         length_count_ff  <= '0;
         length_active_ff <= 1'b0;
         enabled_flag_ff  <= 1'b0;
      end else if (step) begin
         period_count_ff  <= period_count_in;
         duty_position_ff <= duty_position_in;
         freq_value_ff    <= freq_value_in;
         shadow_value_ff  <= shadow_value_in;
         sweep_count_ff   <= sweep_count_in;
         sweep_active_ff  <= sweep_active_in;
         env_count_ff     <= env_count_in;
         volume_now_ff    <= volume_now_in;
         length_count_ff  <= length_count_in;
         length_active_ff <= length_active_in;
         enabled_flag_ff  <= enabled_flag_in;
      end
   end

endmodule

// File: rtl/pcse_checker.sv
// port-level checks for the pulse channel top, bound into it
module pcse_checker
   import pcse_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_beat_type rsp_data
);

   // a held result beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // reset empties the result side
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a fresh result follows an event beat accepted earlier and passed on through the input register
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result beat without a matching event beat");

   // the event side only stalls under result backpressure
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("event side stalled without result backpressure");

endmodule

bind pulse_channel_sweep_envelope_top pcse_checker u_pcse_checker (.*);

// File: tb/pulse_channel_sweep_envelope_top_tb.sv
`timescale 1ns / 1ps
// pulse channel testbench: directed and random event streams checked against a local channel model
module pulse_channel_sweep_envelope_top_tb;
   import pcse_pkg::*;

   // longest stretch with no beat on any channel before the run is declared hung
   localparam int WATCHDOG_LIMIT = 2000;
   // cycles allowed for the two-stage pipe to settle before a register write or the end
   localparam int DRAIN_CYCLES = 8;
   localparam int EVENTS_PER_PHASE = 200;
   localparam int RANDOM_PHASES = 10;
   // top of the request codes the block ignores
   localparam logic [3:0] EV_UNUSED_TOP = 4'd15;
   // duty waveforms, one byte per select value, msb is the first step
   localparam logic [31:0] DUTY_WAVES = {8'hfc, 8'h0f, 8'h03, 8'h01};

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_beat_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_beat_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [7:0]   csr_wdata = '0;

   always #6 clock = ~clock;

   pulse_channel_sweep_envelope_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // local copy of the channel registers, as they stand after reset
   cfg_type     cfg = '0;
   logic [13:0] period_count = '0;
   logic [2:0]  duty_pos = '0;
   logic [10:0] freq_now = '0;
   logic [10:0] shadow_freq = '0;
   logic [3:0]  sweep_count = '0;
   logic        sweep_armed = 1'b0;
   logic [2:0]  env_count = '0;
   logic [3:0]  volume = '0;
   logic [6:0]  len_count = '0;
   logic        len_active = 1'b0;
   logic        chan_on = 1'b0;

   // channel outputs still owed by the block, oldest first
   rsp_beat_type due_outputs[$];

   bit quiet_run = 1'b0;     // no idling on either side while set
   int fail_count = 0;
   int events_sent = 0;
   int results_seen = 0;
   int csr_writes = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   // ------------------------------------------------------------------
   // channel model
   // ------------------------------------------------------------------

   // sweep target from the shadow frequency; anything past 11 bits kills the channel
   function automatic logic [11:0] sweep_probe();
      logic [10:0] delta;
      logic [11:0] target;
      delta = shadow_freq >> cfg.sweep_shift;
      if (cfg.sweep_subtract) target = {1'b0, shadow_freq} - {1'b0, delta};
      else                    target = {1'b0, shadow_freq} + {1'b0, delta};
      if (target[11]) chan_on = 1'b0;
      return target;
   endfunction

   function automatic void length_tick();
      if (len_active) begin
         if (len_count != 0) len_count = len_count - 7'd1;
         if (len_count == 0) chan_on = 1'b0;
      end
   endfunction

   // applies one event to the local registers and returns what the channel should report
   function automatic rsp_beat_type channel_update(input req_beat_type ev);
      logic [11:0]  target;
      logic         wave_bit;
      rsp_beat_type r;
      case (ev.req_type)
         EV_TICK: begin
            if (period_count <= 14'd1) begin
               period_count = (14'd2048 - {3'b000, freq_now}) << 2;
               duty_pos = duty_pos + 3'd1;
            end else begin
               period_count = period_count - 14'd1;
            end
         end
         EV_LEN_CLK: length_tick();
         EV_ENV_CLK: begin
            // a zero period freezes the volume altogether
            if (cfg.env_period != 0) begin
               if (env_count != 0) env_count = env_count - 3'd1;
               if (env_count == 0) begin
                  env_count = cfg.env_period;
                  if (cfg.env_increase && volume != 4'd15) volume = volume + 4'd1;
                  else if (!cfg.env_increase && volume != 0) volume = volume - 4'd1;
               end
            end
         end
         EV_SWEEP_CLK: begin
            if (sweep_count != 0) sweep_count = sweep_count - 4'd1;
            if (sweep_count == 0) begin
               sweep_count = (cfg.sweep_period != 0) ? {1'b0, cfg.sweep_period} : 4'd8;
               if (sweep_armed && cfg.sweep_period != 0) begin
                  target = sweep_probe();
                  // an overflowing target is never stored; a zero shift stores nothing
                  if (!target[11] && cfg.sweep_shift != 0) begin
                     freq_now = target[10:0];
                     shadow_freq = target[10:0];
                     void'(sweep_probe());
                  end
               end
            end
         end
         EV_TRIGGER: begin
            // duty position and timer are left alone on a trigger
            chan_on = 1'b1;
            shadow_freq = freq_now;
            sweep_count = (cfg.sweep_period != 0) ? {1'b0, cfg.sweep_period} : 4'd8;
            sweep_armed = (cfg.sweep_period != 0 || cfg.sweep_shift != 0);
            if (cfg.sweep_shift != 0) void'(sweep_probe());
            volume = cfg.env_start_volume;
            env_count = cfg.env_period;
            if (len_count == 0) len_count = 7'd64;
         end
         EV_FREQ_LO: freq_now[7:0] = ev.data_byte;
         EV_FREQ_HI: freq_now[10:8] = ev.data_byte[2:0];
         EV_LEN_LOAD: len_count = 7'd64 - {1'b0, ev.data_byte[5:0]};
         EV_LEN_ENABLE: begin
            // switching the counter on with the condition set costs one extra length clock
            if (!len_active && ev.length_on && ev.extra_clock_cond) begin
               len_active = 1'b1;
               length_tick();
            end else begin
               len_active = ev.length_on;
            end
         end
         default: ;  // unused codes only report
      endcase
      // amplitude is not gated by the enable flag
      wave_bit = DUTY_WAVES[{cfg.duty_select, ~duty_pos}];
      r.amplitude = wave_bit ? volume : 4'd0;
      r.channel_on = chan_on;
      r.frequency = freq_now;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------

   // per-beat wait on either side: mostly none, sometimes short, now and then from a wider random range
   function automatic int draw_wait();
      if (quiet_run) return 0;
      case ($urandom_range(0, 3))
         0, 1:    return 0;
         2:       return $urandom_range(1, 3);
         default: return $urandom_range(0, 18);
      endcase
   endfunction

   // one event beat; valid stays high afterwards so back-to-back beats need no dip
   task automatic send_event(input logic [3:0] kind, input logic [7:0] data,
                             input logic on, input logic cond);
      int           gap;
      req_beat_type ev;
      ev = '{req_type: kind, data_byte: data, length_on: on, extra_clock_cond: cond};
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= ev;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      due_outputs.push_back(channel_update(ev));
      events_sent++;
   endtask

   // drop valid and let every owed result come out before touching the registers
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (due_outputs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one register write; bits above the field are random so the block must mask them
   task automatic write_reg(input logic [2:0] idx, input logic [7:0] field,
                            input logic [7:0] mask);
      logic [7:0] w;
      w = (8'($urandom_range(0, 255)) & ~mask) | (field & mask);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= w;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_SWEEP_PERIOD:   cfg.sweep_period = w[2:0];
         CSR_SWEEP_SUBTRACT: cfg.sweep_subtract = w[0];
         CSR_SWEEP_SHIFT:    cfg.sweep_shift = w[2:0];
         CSR_DUTY_SELECT:    cfg.duty_select = w[1:0];
         CSR_ENV_START_VOL:  cfg.env_start_volume = w[3:0];
         CSR_ENV_INCREASE:   cfg.env_increase = w[0];
         CSR_ENV_PERIOD:     cfg.env_period = w[2:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic load_settings(input cfg_type c);
      wait_idle();
      write_reg(CSR_SWEEP_PERIOD,   {5'd0, c.sweep_period},     8'h07);
      write_reg(CSR_SWEEP_SUBTRACT, {7'd0, c.sweep_subtract},   8'h01);
      write_reg(CSR_SWEEP_SHIFT,    {5'd0, c.sweep_shift},      8'h07);
      write_reg(CSR_DUTY_SELECT,    {6'd0, c.duty_select},      8'h03);
      write_reg(CSR_ENV_START_VOL,  {4'd0, c.env_start_volume}, 8'h0f);
      write_reg(CSR_ENV_INCREASE,   {7'd0, c.env_increase},     8'h01);
      write_reg(CSR_ENV_PERIOD,     {5'd0, c.env_period},       8'h07);
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // result side: random stall, and every accepted beat checked against the oldest owed one
   // ------------------------------------------------------------------
   always @(posedge clock) begin : rsp_side
      rsp_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (due_outputs.size() == 0) begin
            $error("result beat with nothing owed: amplitude %0d channel_on %0d frequency %0d",
                   rsp_data.amplitude, rsp_data.channel_on, rsp_data.frequency);
            fail_count++;
         end else begin
            want = due_outputs.pop_front();
            if (rsp_data.amplitude !== want.amplitude) begin
               $error("amplitude: expected %0d, got %0d", want.amplitude, rsp_data.amplitude);
               fail_count++;
            end
            if (rsp_data.channel_on !== want.channel_on) begin
               $error("channel_on: expected %0d, got %0d", want.channel_on, rsp_data.channel_on);
               fail_count++;
            end
            if (rsp_data.frequency !== want.frequency) begin
               $error("frequency: expected %0d, got %0d", want.frequency, rsp_data.frequency);
               fail_count++;
            end
         end
         hold_left = draw_wait();
      end else if (hold_left > 0) begin
         hold_left--;
      end
      rsp_stall <= (hold_left != 0);
   end

   // hang detector: counts cycles in which no beat moves on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat moved for %0d cycles, %0d results still owed",
                  WATCHDOG_LIMIT, due_outputs.size());
         $display("pulse_channel_sweep_envelope_top regression: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // full-scale frequency gives the shortest timer reload, so the duty steps show quickly
   task automatic test_duty_timer();
      load_settings('{sweep_period: 3'd7, sweep_subtract: 1'b1, sweep_shift: 3'd7,
                      duty_select: 2'd3, env_start_volume: 4'd15, env_increase: 1'b0,
                      env_period: 3'd1});
      send_event(EV_FREQ_LO, 8'hff, 1'b1, 1'b1);
      send_event(EV_FREQ_HI, 8'hff, 1'b0, 1'b0);   // only the low three bits count
      repeat (5) send_event(EV_TICK, 8'h00, 1'b0, 1'b0);
   endtask

   // trigger loads the volume, the envelope steps down, then the length counter runs
   task automatic test_envelope_length();
      send_event(EV_TRIGGER, 8'h00, 1'b0, 1'b0);      // subtracting sweep, no overflow
      send_event(EV_ENV_CLK, 8'h00, 1'b0, 1'b0);
      send_event(EV_SWEEP_CLK, 8'h00, 1'b0, 1'b0);
      send_event(EV_LEN_LOAD, 8'h00, 1'b0, 1'b0);     // full length of 64
      send_event(EV_LEN_ENABLE, 8'h00, 1'b1, 1'b1);   // off to on with the extra clock
      send_event(EV_LEN_CLK, 8'h00, 1'b0, 1'b0);
      send_event(EV_UNUSED_TOP, 8'hff, 1'b1, 1'b1);   // ignored code, reports only
   endtask

   // adding sweep with shift 1: one good update, then a trigger that overflows
   task automatic test_sweep_overflow();
      load_settings('{sweep_period: 3'd1, sweep_subtract: 1'b0, sweep_shift: 3'd1,
                      duty_select: 2'd0, env_start_volume: 4'd0, env_increase: 1'b1,
                      env_period: 3'd7});
      send_event(EV_FREQ_HI, 8'h00, 1'b0, 1'b0);
      send_event(EV_TRIGGER, 8'h00, 1'b0, 1'b0);
      send_event(EV_SWEEP_CLK, 8'h00, 1'b0, 1'b0);
      send_event(EV_ENV_CLK, 8'h00, 1'b0, 1'b0);
      send_event(EV_LEN_LOAD, 8'hff, 1'b0, 1'b0);     // shortest length of 1
      send_event(EV_LEN_CLK, 8'h00, 1'b0, 1'b0);      // runs out, channel off
      send_event(EV_LEN_ENABLE, 8'h00, 1'b0, 1'b0);
      send_event(EV_FREQ_HI, 8'h07, 1'b0, 1'b0);
      send_event(EV_TRIGGER, 8'h00, 1'b0, 1'b0);      // sweep target past 2047
      send_event(EV_LEN_ENABLE, 8'h00, 1'b1, 1'b0);   // on without the extra clock
   endtask

   // weighted event mix; timer ticks dominate since the duty pattern needs many of them
   function automatic logic [3:0] pick_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return EV_TICK;
      if (r < 50) return EV_LEN_CLK;
      if (r < 63) return EV_ENV_CLK;
      if (r < 76) return EV_SWEEP_CLK;
      if (r < 81) return EV_TRIGGER;
      if (r < 85) return EV_FREQ_LO;
      if (r < 89) return EV_FREQ_HI;
      if (r < 92) return EV_LEN_LOAD;
      if (r < 97) return EV_LEN_ENABLE;
      return 4'($urandom_range(int'(EV_LEN_ENABLE) + 1, int'(EV_UNUSED_TOP)));
   endfunction

   // phases of random events, each under new settings; the first two are all-zero and all-ones
   task automatic test_random_traffic();
      cfg_type                    c;
      logic [$bits(cfg_type)-1:0] raw;
      logic [7:0]                 hi_byte;
      logic [3:0]                 kind;
      int                         counted;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       raw = '0;
            1:       raw = '1;
            default: raw = ($bits(cfg_type))'($urandom);
         endcase
         c = raw;
         load_settings(c);
         // every fourth phase runs with no idling on either side
         quiet_run = (phase % 4 == 3);
         counted = 0;
         while (counted < EVENTS_PER_PHASE) begin
            if ($urandom_range(0, 9) == 0) begin
               // set up a note the usual way: frequency, length, enable, then trigger
               hi_byte = 8'($urandom_range(0, 255));
               if ($urandom_range(0, 1) == 1) hi_byte[2:0] = 3'b111;  // fast timer
               send_event(EV_FREQ_LO, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
               send_event(EV_FREQ_HI, hi_byte,
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
               send_event(EV_LEN_LOAD, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
               send_event(EV_LEN_ENABLE, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
               send_event(EV_TRIGGER, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
               counted += 5;
            end else begin
               kind = pick_kind();
               send_event(kind, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
               if (kind <= EV_LEN_ENABLE) counted++;
            end
         end
      end
      quiet_run = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_duty_timer();
      test_envelope_length();
      test_sweep_overflow();
      test_random_traffic();
      wait_idle();
      $display("run covered %0d event beats and %0d result beats", events_sent, results_seen);
      $display("across %0d register writes in %0d random phases plus directed settings",
               csr_writes, RANDOM_PHASES);
      if (fail_count == 0)
         $display("pulse_channel_sweep_envelope_top regression: pass");
      else
         $display("pulse_channel_sweep_envelope_top regression: fail");
      $finish;
   end

endmodule

// File: sim.f
rtl/pcse_pkg.sv
rtl/pcse_csr.sv
rtl/pcse_core.sv
rtl/pulse_channel_sweep_envelope_top.sv
rtl/pcse_checker.sv
tb/pulse_channel_sweep_envelope_top_tb.sv
